// ===== design/pidaw_pkg.sv =====
package pidaw_pkg;

    localparam int FRAC_SHIFT_DEFAULT = 10;

    localparam int DATA_W  = 16;
    localparam int ERR_W   = 17;
    localparam int GAIN_W  = 20;
    localparam int WORD_W  = 32;
    localparam int BOUND_W = 31;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int DIV_STEPS = WORD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_HIGH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_LOW  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND      = 3'd6;

    localparam logic FUNC_STEP  = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    localparam logic MODE_POSITIONAL  = 1'b0;
    localparam logic MODE_INCREMENTAL = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_P_ADD,
        ST_P_BOUND,
        ST_P_MUL0,
        ST_P_MUL1,
        ST_P_MUL2,
        ST_P_MUL3,
        ST_P_SHIFT,
        ST_P_SAT,
        ST_P_NUM,
        ST_P_START,
        ST_P_DIV,
        ST_P_LIM,
        ST_I_MUL0,
        ST_I_MUL1,
        ST_I_MUL2,
        ST_I_MUL3,
        ST_I_SUM,
        ST_CLAMP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ===== design/pidaw_mul.sv =====
module pidaw_mul
    import pidaw_pkg::*;
(
    input  logic                     clk,
    input  logic [GAIN_W-1:0]        gain,
    input  logic signed [WORD_W-1:0] operand,
    output logic signed [WORD_W-1:0] product
);

    logic signed [GAIN_W:0]          gain_s;
    logic signed [GAIN_W+WORD_W:0]   full;
    logic signed [WORD_W-1:0]        product_reg;

    // Only the low word is kept, so the product wraps like 32-bit C arithmetic.
    assign gain_s = $signed({1'b0, gain});
    assign full   = gain_s * operand;

    always_ff @(posedge clk)
    begin
        product_reg <= full[WORD_W-1:0];
    end

    assign product = product_reg;

endmodule

// ===== design/pidaw_div.sv =====
module pidaw_div
    import pidaw_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [WORD_W-1:0] dividend,
    input  logic [GAIN_W-1:0]        divisor,
    output logic signed [WORD_W-1:0] quotient,
    output div_status_t              status
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 neg_reg, neg_next;
    logic [GAIN_W-1:0]    rem_reg, rem_next;
    logic [WORD_W-1:0]    quo_reg, quo_next;

    logic [GAIN_W:0]      shifted;
    logic [GAIN_W:0]      trial;
    logic                 fits;

    assign shifted = {rem_reg, quo_reg[WORD_W-1]};
    assign fits    = shifted >= {1'b0, divisor};
    assign trial   = shifted - {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            // Work on the magnitude; the sign goes back on at the end so the
            // quotient truncates toward zero.
            busy_next = 1'b1;
            cnt_next  = '0;
            neg_next  = dividend[WORD_W-1];
            rem_next  = '0;
            quo_next  = dividend[WORD_W-1] ? WORD_W'(-dividend) : WORD_W'(dividend);
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial[GAIN_W-1:0] : shifted[GAIN_W-1:0];
            quo_next = {quo_reg[WORD_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient    = neg_reg ? $signed(-quo_reg) : $signed(quo_reg);
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== design/pid_fixed_point_antiwindup_core.sv =====
// Fixed-point PID controller with anti-windup, positional or incremental.
// Input channel (in_valid/in_ready) carries func, setpoint and measured; a
// func of one clears the loop state and returns a drive of zero. Output
// channel (out_valid/out_ready) carries the clamped drive, one per input.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready and must only be written while no transaction is in flight.
// One shared multiplier computes the three gain products one after another,
// and a radix-2 serial divider back-calculates the integral limit.
// A clear goes straight to the output; incremental mode runs the three gain
// products and their sum; positional mode also accumulates and bounds the
// integral and, when the output saturates with a nonzero integral gain,
// waits for the divider. One item is in work at a time; in_ready rises
// again in the cycle the result is loaded.
// The result sits in an output register, so the next item can be accepted
// while out_ready is low; a further result waits until that one is taken.
// Reset clears the loop state and restores the register defaults (zero
// gains, full 16-bit output range, maximum integral bound, positional).
module pid_fixed_point_antiwindup_core
    import pidaw_pkg::*;
#(
    parameter int FRAC_SHIFT = FRAC_SHIFT_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     func,
    input  logic signed [DATA_W-1:0] setpoint,
    input  logic signed [DATA_W-1:0] measured,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] drive,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    state_t state_reg, state_next;

    logic                     mode_reg;
    logic [GAIN_W-1:0]        gain_p_reg, gain_i_reg, gain_d_reg;
    logic signed [DATA_W-1:0] limit_high_reg, limit_low_reg;
    logic [BOUND_W-1:0]       bound_reg;

    logic signed [WORD_W-1:0] acc_reg, acc_next;
    logic signed [ERR_W-1:0]  prior_err_reg, prior_err_next;
    logic signed [ERR_W-1:0]  older_err_reg, older_err_next;
    logic signed [DATA_W-1:0] run_out_reg, run_out_next;

    logic signed [ERR_W-1:0]  err_reg, err_next;
    logic signed [WORD_W-1:0] sum_reg, sum_next;
    logic signed [WORD_W-1:0] pt_reg, pt_next;
    logic signed [WORD_W-1:0] dt_reg, dt_next;
    logic signed [WORD_W-1:0] res_reg, res_next;
    logic signed [WORD_W-1:0] num_reg, num_next;
    logic                     sat_high_reg, sat_high_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] drive_reg, drive_next;

    logic [GAIN_W-1:0]        mul_gain;
    logic signed [WORD_W-1:0] mul_operand;
    logic signed [WORD_W-1:0] mul_product;
    logic                     div_start;
    logic signed [WORD_W-1:0] div_quotient;
    div_status_t              div_status;

    logic                     in_fire;
    logic                     out_load;
    logic signed [WORD_W-1:0] err_w, diff_w, idiff_w;
    logic signed [ERR_W:0]    diff1;
    logic signed [ERR_W+2:0]  diff2;
    logic signed [WORD_W-1:0] limit_high_w, limit_low_w;
    logic signed [WORD_W-1:0] limit_high_sh, limit_low_sh;
    logic signed [WORD_W-1:0] bound_w;
    logic signed [WORD_W-1:0] shifted_sum;
    logic signed [WORD_W-1:0] clamped;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_load  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

    assign err_w        = WORD_W'(err_reg);
    assign diff1        = (ERR_W+1)'(err_reg) - (ERR_W+1)'(prior_err_reg);
    assign diff_w       = WORD_W'(diff1);
    assign diff2        = err_reg - (prior_err_reg <<< 1) + older_err_reg;
    assign idiff_w      = WORD_W'(diff2);
    assign limit_high_w = WORD_W'(limit_high_reg);
    assign limit_low_w  = WORD_W'(limit_low_reg);
    assign limit_high_sh = limit_high_w <<< FRAC_SHIFT;
    assign limit_low_sh  = limit_low_w <<< FRAC_SHIFT;
    assign bound_w      = $signed({1'b0, bound_reg});
    assign shifted_sum  = sum_reg >>> FRAC_SHIFT;

    always_comb
    begin
        if (res_reg > limit_high_w)
            clamped = limit_high_w;
        else if (res_reg < limit_low_w)
            clamped = limit_low_w;
        else
            clamped = res_reg;
    end

    pidaw_mul u_mul (
        .clk     (clk),
        .gain    (mul_gain),
        .operand (mul_operand),
        .product (mul_product)
    );

    pidaw_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_reg),
        .divisor  (gain_i_reg),
        .quotient (div_quotient),
        .status   (div_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_POSITIONAL;
            gain_p_reg     <= '0;
            gain_i_reg     <= '0;
            gain_d_reg     <= '0;
            limit_high_reg <= 16'sh7FFF;
            limit_low_reg  <= -16'sh8000;
            bound_reg      <= '1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MODE:       mode_reg       <= cfg_data[0];
                CFG_GAIN_P:     gain_p_reg     <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:     gain_i_reg     <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:     gain_d_reg     <= cfg_data[GAIN_W-1:0];
                CFG_LIMIT_HIGH: limit_high_reg <= $signed(cfg_data[DATA_W-1:0]);
                CFG_LIMIT_LOW:  limit_low_reg  <= $signed(cfg_data[DATA_W-1:0]);
                CFG_BOUND:      bound_reg      <= cfg_data[BOUND_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (func == FUNC_CLEAR)
                        state_next = ST_DONE;
                    else if (mode_reg == MODE_INCREMENTAL)
                        state_next = ST_I_MUL0;
                    else
                        state_next = ST_P_ADD;
                end
            end
            ST_P_ADD:   state_next = ST_P_BOUND;
            ST_P_BOUND: state_next = ST_P_MUL0;
            ST_P_MUL0:  state_next = ST_P_MUL1;
            ST_P_MUL1:  state_next = ST_P_MUL2;
            ST_P_MUL2:  state_next = ST_P_MUL3;
            ST_P_MUL3:  state_next = ST_P_SHIFT;
            ST_P_SHIFT: state_next = ST_P_SAT;
            ST_P_SAT:
            begin
                if (gain_i_reg != '0 && (res_reg > limit_high_w || res_reg < limit_low_w))
                    state_next = ST_P_NUM;
                else
                    state_next = ST_CLAMP;
            end
            ST_P_NUM:   state_next = ST_P_START;
            ST_P_START: state_next = ST_P_DIV;
            ST_P_DIV:
            begin
                if (div_status.done)
                    state_next = ST_P_LIM;
            end
            ST_P_LIM:   state_next = ST_CLAMP;
            ST_I_MUL0:  state_next = ST_I_MUL1;
            ST_I_MUL1:  state_next = ST_I_MUL2;
            ST_I_MUL2:  state_next = ST_I_MUL3;
            ST_I_MUL3:  state_next = ST_I_SUM;
            ST_I_SUM:   state_next = ST_CLAMP;
            ST_CLAMP:   state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Multiplier operand selection and divider start.
    always_comb
    begin
        mul_gain    = '0;
        mul_operand = '0;
        div_start   = 1'b0;
        unique case (state_reg)
            ST_P_MUL0:
            begin
                mul_gain    = gain_p_reg;
                mul_operand = err_w;
            end
            ST_P_MUL1:
            begin
                mul_gain    = gain_i_reg;
                mul_operand = acc_reg;
            end
            ST_P_MUL2:
            begin
                mul_gain    = gain_d_reg;
                mul_operand = diff_w;
            end
            ST_I_MUL0:
            begin
                mul_gain    = gain_p_reg;
                mul_operand = diff_w;
            end
            ST_I_MUL1:
            begin
                mul_gain    = gain_i_reg;
                mul_operand = err_w;
            end
            ST_I_MUL2:
            begin
                mul_gain    = gain_d_reg;
                mul_operand = idiff_w;
            end
            ST_P_START: div_start = 1'b1;
            default:    ;
        endcase
    end

    always_comb
    begin
        acc_next       = acc_reg;
        prior_err_next = prior_err_reg;
        older_err_next = older_err_reg;
        run_out_next   = run_out_reg;
        err_next       = err_reg;
        sum_next       = sum_reg;
        pt_next        = pt_reg;
        dt_next        = dt_reg;
        res_next       = res_reg;
        num_next       = num_reg;
        sat_high_next  = sat_high_reg;
        out_valid_next = out_valid_reg && !out_ready;
        drive_next     = drive_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    err_next = ERR_W'(setpoint) - ERR_W'(measured);
                    if (func == FUNC_CLEAR)
                    begin
                        acc_next       = '0;
                        prior_err_next = '0;
                        older_err_next = '0;
                        run_out_next   = '0;
                        res_next       = '0;
                    end
                end
            end
            ST_P_ADD:   acc_next = acc_reg + err_w;
            ST_P_BOUND:
            begin
                if (acc_reg > bound_w)
                    acc_next = bound_w;
                else if (acc_reg < -bound_w)
                    acc_next = -bound_w;
            end
            ST_P_MUL1:
            begin
                pt_next  = mul_product;
                sum_next = mul_product;
            end
            ST_P_MUL2:  sum_next = sum_reg + mul_product;
            ST_P_MUL3:
            begin
                dt_next  = mul_product;
                sum_next = sum_reg + mul_product;
            end
            ST_P_SHIFT: res_next = shifted_sum;
            ST_P_SAT:
            begin
                // The upper limit is checked first, which also settles
                // inverted limits.
                sat_high_next = res_reg > limit_high_w;
                num_next = (res_reg > limit_high_w) ? limit_high_sh - pt_reg
                                                    : limit_low_sh - pt_reg;
            end
            ST_P_NUM:   num_next = num_reg - dt_reg;
            ST_P_LIM:
            begin
                if (sat_high_reg)
                begin
                    if (acc_reg > div_quotient && div_quotient > 0)
                        acc_next = div_quotient;
                    res_next = limit_high_w;
                end
                else
                begin
                    if (acc_reg < div_quotient && div_quotient < 0)
                        acc_next = div_quotient;
                    res_next = limit_low_w;
                end
            end
            ST_I_MUL1:  sum_next = mul_product;
            ST_I_MUL2:  sum_next = sum_reg + mul_product;
            ST_I_MUL3:  sum_next = sum_reg + mul_product;
            ST_I_SUM:   res_next = WORD_W'(run_out_reg) + shifted_sum;
            ST_CLAMP:
            begin
                res_next       = clamped;
                prior_err_next = err_reg;
                if (mode_reg == MODE_INCREMENTAL)
                begin
                    older_err_next = prior_err_reg;
                    run_out_next   = clamped[DATA_W-1:0];
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    drive_next     = res_reg[DATA_W-1:0];
                end
            end
            default:    ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            prior_err_reg <= '0;
            older_err_reg <= '0;
            run_out_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            acc_reg       <= acc_next;
            prior_err_reg <= prior_err_next;
            older_err_reg <= older_err_next;
            run_out_reg   <= run_out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg      <= err_next;
        sum_reg      <= sum_next;
        pt_reg       <= pt_next;
        dt_reg       <= dt_next;
        res_reg      <= res_next;
        num_reg      <= num_next;
        sat_high_reg <= sat_high_next;
        drive_reg    <= drive_next;
    end

endmodule
